// ----- design/erf_pkg.sv -----
package erf_pkg;

	localparam int FRAC_BITS = 16;

	localparam int GAMMA_W = 18;
	localparam int STEP_W  = 31;
	localparam int CFG_W   = 31;
	localparam int DEN_W   = 31;

	// divider: one quotient bit per stage, sized for the wider of the two divides
	localparam int DIV_NUM_W = (32 + FRAC_BITS > GAMMA_W + 31) ? 32 + FRAC_BITS : GAMMA_W + 31;
	localparam int DIV_N     = DIV_NUM_W;

	// square root of c2 scaled by the fraction bits, two radicand bits per stage
	localparam int SQ_N    = (32 + FRAC_BITS) / 2;
	localparam int SQ_IN_W = 2 * SQ_N;

	localparam int MU16_W = 64 - FRAC_BITS;
	localparam int F1_W   = MU16_W + 1;
	localparam int FS_W   = 68 - FRAC_BITS;
	localparam int K_W    = 33;

	localparam int SIDE_LAT  = 9 + 2 * DIV_N + SQ_N;
	localparam int FLUX_LAT  = 5;
	localparam int TOTAL_LAT = SIDE_LAT + FLUX_LAT;

	localparam int FIFO_DEPTH = 2;

	localparam logic [GAMMA_W-1:0] GAMMA_RST = GAMMA_W'(91750);
	localparam logic [STEP_W-1:0]  STEP_RST  = STEP_W'(66);

	localparam logic signed [GAMMA_W:0] ONE_FX = (GAMMA_W + 1)'(1 << FRAC_BITS);

	localparam logic signed [63:0] LIM_HI = 64'sd2147483647;
	localparam logic signed [63:0] LIM_LO = -64'sd2147483648;
	localparam logic signed [31:0] S32_MAX = 32'sh7fffffff;
	localparam logic signed [31:0] S32_MIN = 32'sh80000000;

	localparam logic [0:0] CFG_GAMMA = 1'b0;
	localparam logic [0:0] CFG_STEP  = 1'b1;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_DENSITY  = 2'd1;
	localparam logic [1:0] ST_PRESSURE = 2'd2;
	localparam logic [1:0] ST_SAT      = 2'd3;

	typedef struct packed {
		logic        hit;
		logic signed [31:0] val;
	} sat_t;

	typedef struct packed {
		logic signed [31:0]       rho;
		logic signed [31:0]       m;
		logic signed [31:0]       e;
		logic signed [31:0]       u;
		logic signed [31:0]       p;
		logic signed [MU16_W-1:0] mu16;
		logic [K_W-1:0]           k;
		logic                     bad_d;
		logic                     bad_p;
		logic                     sat;
	} side_res_t;

	typedef struct packed {
		logic signed [31:0] mass;
		logic signed [31:0] mom;
		logic signed [31:0] energy;
		logic [1:0]         status;
	} flux_out_t;

	function automatic sat_t sat32(input logic signed [63:0] v);
		sat_t r;
		if (v > LIM_HI) begin
			r.hit = 1'b1;
			r.val = S32_MAX;
		end else if (v < LIM_LO) begin
			r.hit = 1'b1;
			r.val = S32_MIN;
		end else begin
			r.hit = 1'b0;
			r.val = v[31:0];
		end
		return r;
	endfunction

endpackage

// ----- design/euler_rusanov_flux_1d_core.sv -----
// rusanov (local lax-friedrichs) flux for 1d euler, one cell interface per beat.
// a beat carries left and right conservative states (density, momentum, energy),
// all signed q16.16; the result beat carries dt-scaled mass, momentum and energy
// fluxes, saturated to 32 bits, plus a status code (0 ok, 1 non-positive density,
// 2 negative pressure, 3 a clamp somewhere on the way). error beats carry zero
// fluxes. the core takes one beat every cycle unless a stalled output fills the
// output buffer; the pipe holds the two bit-per-stage dividers (velocity m/rho
// and sound speed gamma*p/rho, 49 stages each) and the 24-stage square root on
// each side, plus 14 stages of multiply and clamp. a stalled
// output freezes the whole pipe in place; a two-beat output buffer keeps the
// input ready free of any combinational path from m_tready. gamma_ratio and
// time_step must only be written while nothing is in flight.
module euler_rusanov_flux_1d_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [0:0]    cfg_index,
	input  logic [30:0]   cfg_data,
	input  logic          s_tvalid,
	output logic          s_tready,
	// left_density, left_momentum, left_energy, right_density, right_momentum,
	// right_energy (32 bits each, from bit 0 up)
	input  logic [191:0]  s_tdata,
	output logic          m_tvalid,
	input  logic          m_tready,
	// mass_flux [31:0], momentum_flux [63:32], energy_flux [95:64],
	// status [97:96], zero fill above
	output logic [103:0]  m_tdata
);
	import erf_pkg::*;

	logic [GAMMA_W-1:0]   gamma_q;
	logic [STEP_W-1:0]    step_q;

	// one valid bit per pipeline stage, moved by the shared enable
	logic [TOTAL_LAT-1:0] vld_q;
	logic                 en;

	side_res_t            left_res, right_res;
	flux_out_t            flux_res;

	// output buffer
	flux_out_t            fifo_q [FIFO_DEPTH];
	logic                 wr_q, rd_q;
	logic [1:0]           cnt_q;
	logic                 push, pop;
	flux_out_t            head;

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gamma_q <= GAMMA_RST;
			step_q  <= STEP_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_GAMMA: gamma_q <= cfg_data[GAMMA_W-1:0];
				CFG_STEP:  step_q  <= cfg_data[STEP_W-1:0];
				default:   ;
			endcase
		end
	end

	// pipe moves unless a finished beat has nowhere to go
	assign en       = !(vld_q[TOTAL_LAT-1] && (cnt_q == 2'(FIFO_DEPTH)));
	assign s_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else if (en)
			vld_q <= {vld_q[TOTAL_LAT-2:0], s_tvalid};
	end

	erf_side u_left (
		.clk    (clk),
		.en     (en),
		.gamma  (gamma_q),
		.rho    ($signed(s_tdata[31:0])),
		.mom    ($signed(s_tdata[63:32])),
		.energy ($signed(s_tdata[95:64])),
		.res    (left_res)
	);

	erf_side u_right (
		.clk    (clk),
		.en     (en),
		.gamma  (gamma_q),
		.rho    ($signed(s_tdata[127:96])),
		.mom    ($signed(s_tdata[159:128])),
		.energy ($signed(s_tdata[191:160])),
		.res    (right_res)
	);

	// beta, flux sum, dissipation, dt scaling
	erf_flux u_flux (
		.clk       (clk),
		.en        (en),
		.time_step (step_q),
		.lft       (left_res),
		.rgt       (right_res),
		.out       (flux_res)
	);

	assign push = en && vld_q[TOTAL_LAT-1];
	assign pop  = m_tvalid && m_tready;

	always_ff @(posedge clk) begin
		if (push)
			fifo_q[wr_q] <= flux_res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= !wr_q;
			if (pop)
				rd_q <= !rd_q;
			if (push && !pop)
				cnt_q <= cnt_q + 2'd1;
			else if (pop && !push)
				cnt_q <= cnt_q - 2'd1;
		end
	end

	assign head     = fifo_q[rd_q];
	assign m_tvalid = (cnt_q != '0);
	assign m_tdata  = {6'b0, head.status, head.energy, head.mom, head.mass};

`ifndef SYNTH
	a_fifo_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 2'(FIFO_DEPTH))
		else $error("output buffer overfilled");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tdata[97:96] == ST_DENSITY || m_tdata[97:96] == ST_PRESSURE))
		|-> (m_tdata[95:0] == '0))
		else $error("error beat with nonzero flux");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !push && cnt_q == 2'd1) |=> !m_tvalid)
		else $error("output valid after last beat drained");
`endif

endmodule

// ----- design/erf_div.sv -----
module erf_div (
	input  logic                           clk,
	input  logic                           en,
	input  logic [erf_pkg::DIV_NUM_W-1:0]  num,
	input  logic [erf_pkg::DEN_W-1:0]      den,
	output logic [erf_pkg::DIV_NUM_W-1:0]  quo
);
	import erf_pkg::*;

	// restoring divide, msb first; nq holds leftover dividend bits above new quotient bits
	logic [DEN_W-1:0]     rem_s [DIV_N];
	logic [DIV_NUM_W-1:0] nq_s  [DIV_N];
	logic [DEN_W-1:0]     d_s   [DIV_N];

	logic [DEN_W-1:0]     rem_in [DIV_N];
	logic [DIV_NUM_W-1:0] nq_in  [DIV_N];
	logic [DEN_W-1:0]     d_in   [DIV_N];
	logic [DEN_W:0]       trial  [DIV_N];
	logic                 take   [DIV_N];

	always_comb begin
		rem_in[0] = '0;
		nq_in[0]  = num;
		d_in[0]   = den;
		for (int i = 1; i < DIV_N; i++) begin
			rem_in[i] = rem_s[i-1];
			nq_in[i]  = nq_s[i-1];
			d_in[i]   = d_s[i-1];
		end
		for (int i = 0; i < DIV_N; i++) begin
			trial[i] = {rem_in[i], nq_in[i][DIV_NUM_W-1]};
			take[i]  = trial[i] >= {1'b0, d_in[i]};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < DIV_N; i++) begin
				rem_s[i] <= take[i] ? DEN_W'(trial[i] - {1'b0, d_in[i]}) : trial[i][DEN_W-1:0];
				nq_s[i]  <= {nq_in[i][DIV_NUM_W-2:0], take[i]};
				d_s[i]   <= d_in[i];
			end
		end
	end

	assign quo = nq_s[DIV_N-1];

endmodule

// ----- design/erf_sqrt.sv -----
module erf_sqrt (
	input  logic                        clk,
	input  logic                        en,
	input  logic [erf_pkg::SQ_IN_W-1:0] rad,
	output logic [erf_pkg::SQ_N-1:0]    root
);
	import erf_pkg::*;

	localparam int REM_W = SQ_N + 2;

	logic [REM_W-1:0]   rem_s  [SQ_N];
	logic [SQ_N-1:0]    root_s [SQ_N];
	logic [SQ_IN_W-1:0] x_s    [SQ_N];

	logic [REM_W-1:0]   rem_in  [SQ_N];
	logic [SQ_N-1:0]    root_in [SQ_N];
	logic [SQ_IN_W-1:0] x_in    [SQ_N];
	logic [REM_W+1:0]   cat     [SQ_N];
	logic [REM_W+1:0]   trial   [SQ_N];
	logic               take    [SQ_N];

	always_comb begin
		rem_in[0]  = '0;
		root_in[0] = '0;
		x_in[0]    = rad;
		for (int i = 1; i < SQ_N; i++) begin
			rem_in[i]  = rem_s[i-1];
			root_in[i] = root_s[i-1];
			x_in[i]    = x_s[i-1];
		end
		for (int i = 0; i < SQ_N; i++) begin
			cat[i]   = {rem_in[i], x_in[i][SQ_IN_W-1 -: 2]};
			trial[i] = (REM_W + 2)'({root_in[i], 2'b01});
			take[i]  = cat[i] >= trial[i];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < SQ_N; i++) begin
				rem_s[i]  <= take[i] ? REM_W'(cat[i] - trial[i]) : cat[i][REM_W-1:0];
				root_s[i] <= {root_in[i][SQ_N-2:0], take[i]};
				x_s[i]    <= {x_in[i][SQ_IN_W-3:0], 2'b00};
			end
		end
	end

	assign root = root_s[SQ_N-1];

endmodule

// ----- design/erf_side.sv -----
module erf_side (
	input  logic                       clk,
	input  logic                       en,
	input  logic [erf_pkg::GAMMA_W-1:0] gamma,
	input  logic signed [31:0]         rho,
	input  logic signed [31:0]         mom,
	input  logic signed [31:0]         energy,
	output erf_pkg::side_res_t         res
);
	import erf_pkg::*;

	typedef struct packed {
		logic signed [31:0]       rho;
		logic signed [31:0]       m;
		logic signed [31:0]       e;
		logic signed [31:0]       u;
		logic signed [31:0]       p;
		logic signed [MU16_W-1:0] mu16;
		logic                     neg;
		logic                     bad_d;
		logic                     bad_p;
		logic                     sat;
	} car_t;

	car_t car_s1, car_s2, car_s3, car_s4, car_s5, car_s6, car_s7, car_s8;
	car_t dly1_s [DIV_N];
	car_t dly2_s [DIV_N];
	car_t dly3_s [SQ_N];

	logic [DIV_NUM_W-1:0]     num_s1;
	logic [DIV_NUM_W-1:0]     q1, q2;
	logic signed [63:0]       mu_s3;
	logic signed [31:0]       eint_s4;
	logic signed [GAMMA_W+32:0] pe_s5;
	logic [GAMMA_W+30:0]      gp_s7;
	logic [30:0]              c2_s8;
	logic [SQ_N-1:0]          root;

	// stage 1 comb
	car_t               c1;
	logic [31:0]        absm;
	// stage 2 comb
	car_t               c2;
	// stage 4 comb
	car_t               c4;
	logic signed [63:0] eint_w;
	sat_t               eint_sat;
	// stage 6 comb
	car_t               c6;
	sat_t               p_sat;
	// stage 8 comb
	car_t               c8;
	logic signed [GAMMA_W:0] gm1;
	// stage 9 comb
	logic [31:0]        absu;

	always_comb begin
		c1       = '0;
		c1.rho   = rho;
		c1.m     = mom;
		c1.e     = energy;
		c1.neg   = mom[31];
		c1.bad_d = rho[31] || (rho == '0);
		absm     = mom[31] ? 32'(-mom) : 32'(mom);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			car_s1 <= c1;
			num_s1 <= DIV_NUM_W'({absm, {FRAC_BITS{1'b0}}});
		end
	end

	erf_div u_div_vel (
		.clk (clk),
		.en  (en),
		.num (num_s1),
		.den (car_s1.rho[DEN_W-1:0]),
		.quo (q1)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			dly1_s[0] <= car_s1;
			for (int i = 1; i < DIV_N; i++)
				dly1_s[i] <= dly1_s[i-1];
		end
	end

	// velocity, truncated toward zero, clamped
	always_comb begin
		c2 = dly1_s[DIV_N-1];
		if (!c2.neg) begin
			if (|q1[DIV_NUM_W-1:31]) begin
				c2.u   = S32_MAX;
				c2.sat = 1'b1;
			end else begin
				c2.u = $signed({1'b0, q1[30:0]});
			end
		end else begin
			if ((|q1[DIV_NUM_W-1:32]) || (q1[31] && (|q1[30:0]))) begin
				c2.u   = S32_MIN;
				c2.sat = 1'b1;
			end else begin
				c2.u = $signed(32'(-q1[31:0]));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			car_s2 <= c2;
			car_s3 <= car_s2;
			mu_s3  <= car_s2.m * car_s2.u;
		end
	end

	// internal energy; m*u is never negative
	always_comb begin
		c4       = car_s3;
		c4.mu16  = mu_s3[63:FRAC_BITS];
		eint_w   = 64'(car_s3.e) - (mu_s3 >>> (FRAC_BITS + 1));
		eint_sat = sat32(eint_w);
		c4.sat   = car_s3.sat | eint_sat.hit;
		gm1      = $signed({1'b0, gamma}) - ONE_FX;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			car_s4  <= c4;
			eint_s4 <= eint_sat.val;
			car_s5  <= car_s4;
			pe_s5   <= gm1 * eint_s4;
		end
	end

	always_comb begin
		c6       = car_s5;
		p_sat    = sat32(64'(pe_s5 >>> FRAC_BITS));
		c6.p     = p_sat.val;
		c6.bad_p = p_sat.val[31];
		c6.sat   = car_s5.sat | p_sat.hit;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			car_s6 <= c6;
			car_s7 <= car_s6;
			gp_s7  <= gamma * car_s6.p[30:0];
		end
	end

	erf_div u_div_snd (
		.clk (clk),
		.en  (en),
		.num (DIV_NUM_W'(gp_s7)),
		.den (car_s7.rho[DEN_W-1:0]),
		.quo (q2)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			dly2_s[0] <= car_s7;
			for (int i = 1; i < DIV_N; i++)
				dly2_s[i] <= dly2_s[i-1];
		end
	end

	always_comb begin
		c8 = dly2_s[DIV_N-1];
		if (|q2[DIV_NUM_W-1:31])
			c8.sat = 1'b1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			car_s8 <= c8;
			c2_s8  <= (|q2[DIV_NUM_W-1:31]) ? 31'h7fffffff : q2[30:0];
		end
	end

	erf_sqrt u_sqrt (
		.clk  (clk),
		.en   (en),
		.rad  (SQ_IN_W'({c2_s8, {FRAC_BITS{1'b0}}})),
		.root (root)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			dly3_s[0] <= car_s8;
			for (int i = 1; i < SQ_N; i++)
				dly3_s[i] <= dly3_s[i-1];
		end
	end

	assign absu = dly3_s[SQ_N-1].u[31] ? 32'(-dly3_s[SQ_N-1].u) : 32'(dly3_s[SQ_N-1].u);

	always_ff @(posedge clk) begin
		if (en) begin
			res.rho   <= dly3_s[SQ_N-1].rho;
			res.m     <= dly3_s[SQ_N-1].m;
			res.e     <= dly3_s[SQ_N-1].e;
			res.u     <= dly3_s[SQ_N-1].u;
			res.p     <= dly3_s[SQ_N-1].p;
			res.mu16  <= dly3_s[SQ_N-1].mu16;
			res.bad_d <= dly3_s[SQ_N-1].bad_d;
			res.bad_p <= dly3_s[SQ_N-1].bad_p;
			res.sat   <= dly3_s[SQ_N-1].sat;
			res.k     <= K_W'(absu) + K_W'(root);
		end
	end

endmodule

// ----- design/erf_flux.sv -----
module erf_flux (
	input  logic                        clk,
	input  logic                        en,
	input  logic [erf_pkg::STEP_W-1:0]  time_step,
	input  erf_pkg::side_res_t          lft,
	input  erf_pkg::side_res_t          rgt,
	output erf_pkg::flux_out_t          out
);
	import erf_pkg::*;

	localparam int PW = 65;

	logic [30:0]              beta_s1;
	logic signed [F1_W-1:0]   f1l_s1, f1r_s1;
	logic signed [PW-1:0]     pf2l_s1, pf2r_s1;
	logic signed [32:0]       d_s1 [3];
	logic signed [32:0]       fs0_s1;
	logic                     bd_s1, bp_s1, sat_s1;

	logic signed [PW-1:0]     pd_s2 [3];
	logic signed [FS_W-1:0]   fs_s2 [3];
	logic                     bd_s2, bp_s2, sat_s2;

	logic signed [31:0]       half_s3 [3];
	logic                     bd_s3, bp_s3, sat_s3;

	logic signed [63:0]       hp_s4 [3];
	logic                     bd_s4, bp_s4, sat_s4;

	logic [K_W-1:0]           kmax;
	logic                     beta_hit;
	logic signed [32:0]       epl, epr;
	logic signed [FS_W-1:0]   sum [3];
	sat_t                     half_sat [3];
	sat_t                     res_sat [3];
	logic                     half_any, res_any;

	always_comb begin
		kmax     = (lft.k > rgt.k) ? lft.k : rgt.k;
		beta_hit = |kmax[K_W-1:31];
		epl      = 33'(lft.e) + 33'(lft.p);
		epr      = 33'(rgt.e) + 33'(rgt.p);
	end

	// flux halves, wave speed, state jumps
	always_ff @(posedge clk) begin
		if (en) begin
			beta_s1 <= beta_hit ? 31'h7fffffff : kmax[30:0];
			f1l_s1  <= F1_W'(lft.mu16) + F1_W'(lft.p);
			f1r_s1  <= F1_W'(rgt.mu16) + F1_W'(rgt.p);
			pf2l_s1 <= lft.u * epl;
			pf2r_s1 <= rgt.u * epr;
			d_s1[0] <= 33'(rgt.rho) - 33'(lft.rho);
			d_s1[1] <= 33'(rgt.m) - 33'(lft.m);
			d_s1[2] <= 33'(rgt.e) - 33'(lft.e);
			fs0_s1  <= 33'(lft.m) + 33'(rgt.m);
			bd_s1   <= lft.bad_d | rgt.bad_d;
			bp_s1   <= lft.bad_p | rgt.bad_p;
			sat_s1  <= lft.sat | rgt.sat | beta_hit;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++)
				pd_s2[i] <= $signed({1'b0, beta_s1}) * d_s1[i];
			fs_s2[0] <= FS_W'(fs0_s1);
			fs_s2[1] <= FS_W'(f1l_s1) + FS_W'(f1r_s1);
			fs_s2[2] <= FS_W'($signed(pf2l_s1[PW-1:FRAC_BITS]))
			          + FS_W'($signed(pf2r_s1[PW-1:FRAC_BITS]));
			bd_s2  <= bd_s1;
			bp_s2  <= bp_s1;
			sat_s2 <= sat_s1;
		end
	end

	always_comb begin
		half_any = 1'b0;
		for (int i = 0; i < 3; i++) begin
			sum[i]      = fs_s2[i] - FS_W'($signed(pd_s2[i][PW-1:FRAC_BITS]));
			half_sat[i] = sat32(64'(sum[i] >>> 1));
			half_any    = half_any | half_sat[i].hit;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++)
				half_s3[i] <= half_sat[i].val;
			bd_s3  <= bd_s2;
			bp_s3  <= bp_s2;
			sat_s3 <= sat_s2 | half_any;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++)
				hp_s4[i] <= half_s3[i] * $signed({1'b0, time_step});
			bd_s4  <= bd_s3;
			bp_s4  <= bp_s3;
			sat_s4 <= sat_s3;
		end
	end

	always_comb begin
		res_any = 1'b0;
		for (int i = 0; i < 3; i++) begin
			res_sat[i] = sat32(hp_s4[i] >>> FRAC_BITS);
			res_any    = res_any | res_sat[i].hit;
		end
	end

	// errors zero the fluxes; density wins over pressure
	always_ff @(posedge clk) begin
		if (en) begin
			if (bd_s4 || bp_s4) begin
				out.mass   <= '0;
				out.mom    <= '0;
				out.energy <= '0;
				out.status <= bd_s4 ? ST_DENSITY : ST_PRESSURE;
			end else begin
				out.mass   <= res_sat[0].val;
				out.mom    <= res_sat[1].val;
				out.energy <= res_sat[2].val;
				out.status <= (sat_s4 || res_any) ? ST_SAT : ST_OK;
			end
		end
	end

endmodule

// ----- verif/tb_euler_rusanov_flux_1d_core.sv -----
module tb_euler_rusanov_flux_1d_core;
	timeunit 1ns;
	timeprecision 1ps;

	import erf_pkg::*;

	localparam longint Q_ONE = 64'sd65536;

	// per-side primitives of one interface
	typedef struct {
		bit     bad_d;
		bit     bad_p;
		longint u;
		longint p;
		longint k;
	} side_prim_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         cfg_we = 1'b0;
	logic [0:0]   cfg_index = CFG_GAMMA;
	logic [30:0]  cfg_data = '0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	// left_density, left_momentum, left_energy, right_density, right_momentum,
	// right_energy, from bit 0 up
	logic [191:0] s_tdata = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	// mass_flux, momentum_flux, energy_flux, status, zero fill, from bit 0 up
	logic [103:0] m_tdata;

	euler_rusanov_flux_1d_core DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor's own copy of the registers
	longint gamma_q = 91750;
	longint dt_q = 66;
	bit     clamp_seen;

	bit [191:0] interface_q[$];   // interfaces waiting to be driven
	flux_out_t  flux_expect_q[$]; // predicted flux beats, oldest first
	int         fail_cnt = 0;
	int         in_beats = 0;
	int         out_beats = 0;
	int         status_seen[4] = '{0, 0, 0, 0};

	function automatic longint clamp32(longint v);
		if (v > 64'sd2147483647) begin
			clamp_seen = 1'b1;
			return 64'sd2147483647;
		end
		if (v < -64'sd2147483648) begin
			clamp_seen = 1'b1;
			return -64'sd2147483648;
		end
		return v;
	endfunction

	function automatic longint int_sqrt(longint unsigned x);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x)
			b >>= 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return longint'(r);
	endfunction

	// velocity, pressure and fastest wave speed of one conservative state
	function automatic side_prim_t side_primitives(longint rho, longint m, longint e);
		side_prim_t s;
		longint ke, eint, c2, c;
		s = '{0, 0, 0, 0, 0};
		if (rho <= 0) begin
			s.bad_d = 1'b1;
			return s;
		end
		s.u = clamp32((m * Q_ONE) / rho);
		ke = (m * s.u) >>> (FRAC_BITS + 1);
		eint = clamp32(e - ke);
		s.p = clamp32(((gamma_q - Q_ONE) * eint) >>> FRAC_BITS);
		if (s.p < 0) begin
			s.bad_p = 1'b1;
			return s;
		end
		c2 = clamp32((gamma_q * s.p) / rho);
		c = int_sqrt(longint'(c2) << FRAC_BITS);
		s.k = (s.u < 0 ? -s.u : s.u) + c;
		return s;
	endfunction

	function automatic flux_out_t rusanov_flux(bit [191:0] d);
		longint ul[3], ur[3], fl[3], fr[3], res[3];
		longint beta, sum, half;
		side_prim_t l, r;
		flux_out_t f;
		for (int i = 0; i < 3; i++) begin
			ul[i] = longint'($signed(d[32*i +: 32]));
			ur[i] = longint'($signed(d[32*(i+3) +: 32]));
		end
		clamp_seen = 1'b0;
		l = side_primitives(ul[0], ul[1], ul[2]);
		r = side_primitives(ur[0], ur[1], ur[2]);
		f.mass = '0;
		f.mom = '0;
		f.energy = '0;
		// density error wins over pressure error, both zero the fluxes
		if (l.bad_d || r.bad_d || l.bad_p || r.bad_p) begin
			f.status = (l.bad_d || r.bad_d) ? ST_DENSITY : ST_PRESSURE;
			return f;
		end
		beta = clamp32(l.k > r.k ? l.k : r.k);
		fl[0] = ul[1];
		fl[1] = ((ul[1] * l.u) >>> FRAC_BITS) + l.p;
		fl[2] = (l.u * (ul[2] + l.p)) >>> FRAC_BITS;
		fr[0] = ur[1];
		fr[1] = ((ur[1] * r.u) >>> FRAC_BITS) + r.p;
		fr[2] = (r.u * (ur[2] + r.p)) >>> FRAC_BITS;
		for (int i = 0; i < 3; i++) begin
			sum = fl[i] + fr[i] - ((beta * (ur[i] - ul[i])) >>> FRAC_BITS);
			half = clamp32(sum >>> 1);
			res[i] = clamp32((half * dt_q) >>> FRAC_BITS);
		end
		f.mass = res[0][31:0];
		f.mom = res[1][31:0];
		f.energy = res[2][31:0];
		f.status = clamp_seen ? ST_SAT : ST_OK;
		return f;
	endfunction

	function automatic bit [191:0] pack_iface(longint rl, longint ml, longint el,
			longint rr, longint mr, longint er);
		return {er[31:0], mr[31:0], rr[31:0], el[31:0], ml[31:0], rl[31:0]};
	endfunction

	// one side of a random state: mostly physical, sometimes broken
	function automatic void rand_side(output longint rho, output longint m,
			output longint e);
		int unsigned pick;
		longint vel, ke;
		pick = $urandom_range(0, 99);
		if (pick < 8) begin
			rho = longint'($signed($urandom()));
			m = longint'($signed($urandom()));
			e = longint'($signed($urandom()));
			return;
		end
		// mostly small densities, a few heavy ones
		rho = (pick < 15) ? longint'($urandom_range(1, 32'h7fffffff))
			: longint'($urandom_range(600, 32'h0064_0000));
		if (pick < 12)
			rho = -rho;
		vel = longint'($urandom_range(0, 32'h0028_0000)) - 64'sd1310720;
		m = (rho * vel) >>> FRAC_BITS;
		if (m > 64'sd2147483647) m = 64'sd2147483647;
		if (m < -64'sd2147483648) m = -64'sd2147483648;
		ke = (rho > 0) ? ((m * m / rho) >>> 1) : 0;
		// short of kinetic energy gives negative pressure
		if (pick < 20)
			e = ke - longint'($urandom_range(1, 32'h0010_0000));
		else
			e = ke + longint'($urandom_range(0, 32'h0064_0000));
		if (e > 64'sd2147483647) e = 64'sd2147483647;
		if (e < -64'sd2147483648) e = -64'sd2147483648;
	endfunction

	// ---------------------------------------------------------------
	// sender: bursts of random length, random gaps between them
	// ---------------------------------------------------------------
	int burst_left = 0;
	int gap_left = 0;
	always @(posedge clk or negedge arst_n) begin
		logic       nxt_valid;
		bit [191:0] nxt_data;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
		end else begin
			nxt_valid = s_tvalid;
			nxt_data = s_tdata;
			if (s_tvalid && s_tready) begin
				flux_expect_q.push_back(rusanov_flux(s_tdata));
				in_beats++;
				nxt_valid = 1'b0;
			end
			// a held beat stays put until taken
			if (!nxt_valid) begin
				if (burst_left > 0 && interface_q.size() > 0) begin
					nxt_data = interface_q.pop_front();
					nxt_valid = 1'b1;
					burst_left--;
				end else if (gap_left > 0) begin
					gap_left--;
				end else begin
					burst_left = $urandom_range(1, 24);
					// every few bursts run back to back
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
				end
			end
			s_tvalid <= nxt_valid;
			s_tdata <= nxt_data;
		end
	end

	// ---------------------------------------------------------------
	// receiver: stall pattern chosen anew at a regular interval, plus one long hold
	// ---------------------------------------------------------------
	int  rx_cycle = 0;
	int  rx_mode = 0;
	int  hold_cnt = 0;
	bit  hold_done = 1'b0;
	always @(posedge clk or negedge arst_n) begin
		flux_out_t ex;
		logic      nxt_ready;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				out_beats++;
				status_seen[m_tdata[97:96]]++;
				if (flux_expect_q.size() == 0) begin
					$display("%0t: flux beat with nothing expected: %h", $realtime, m_tdata);
					fail_cnt++;
				end else begin
					ex = flux_expect_q.pop_front();
					if (m_tdata[31:0] !== ex.mass) begin
						$display("%0t: mass_flux expected %h got %h", $realtime, ex.mass,
							m_tdata[31:0]);
						fail_cnt++;
					end
					if (m_tdata[63:32] !== ex.mom) begin
						$display("%0t: momentum_flux expected %h got %h", $realtime, ex.mom,
							m_tdata[63:32]);
						fail_cnt++;
					end
					if (m_tdata[95:64] !== ex.energy) begin
						$display("%0t: energy_flux expected %h got %h", $realtime,
							ex.energy, m_tdata[95:64]);
						fail_cnt++;
					end
					if (m_tdata[97:96] !== ex.status) begin
						$display("%0t: status expected %0d got %0d", $realtime, ex.status,
							m_tdata[97:96]);
						fail_cnt++;
					end
				end
			end
			rx_cycle++;
			if (rx_cycle % 64 == 0)
				rx_mode = $urandom_range(0, 2);
			// once, long enough for the pipe to fill and block the input
			if (!hold_done && in_beats >= 700) begin
				hold_done = 1'b1;
				hold_cnt = 400;
			end
			if (hold_cnt > 0) begin
				hold_cnt--;
				nxt_ready = 1'b0;
			end else begin
				case (rx_mode)
					0: nxt_ready = 1'b1;
					1: nxt_ready = ($urandom_range(0, 1) == 1);
					default: nxt_ready = ($urandom_range(0, 3) == 0);
				endcase
			end
			m_tready <= nxt_ready;
		end
	end

	task automatic wait_idle();
		while (interface_q.size() > 0 || s_tvalid || flux_expect_q.size() > 0)
			@(negedge clk);
	endtask

	task automatic write_reg(logic [0:0] idx, longint value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value[30:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_GAMMA)
			gamma_q = value & 64'h3ffff;
		else
			dt_q = value & 64'h7fffffff;
	endtask

	initial begin
		longint gam[5];
		longint dts[5];
		longint rl, ml, el, rr, mr, er;

		gam = '{91750, 65537, 196608, 65536, 262143};
		dts = '{66, 0, 2147483647, 65536, 1};

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed corners under reset settings
		// both densities zero, then left density most negative
		interface_q.push_back('0);
		interface_q.push_back(pack_iface(-64'sd2147483648, 0, 0, 65536, 0, 65536));
		// only right density bad
		interface_q.push_back(pack_iface(65536, 0, 65536, 0, 0, 65536));
		// still air both sides
		interface_q.push_back(pack_iface(65536, 0, 163840, 65536, 0, 163840));
		// shock tube: high pressure left, low right
		interface_q.push_back(pack_iface(65536, 0, 163840, 8192, 0, 16384));
		// negative pressure: left from negative energy, then right from kinetic energy above total
		interface_q.push_back(pack_iface(65536, 0, -65536, 65536, 0, 65536));
		interface_q.push_back(pack_iface(65536, 65536, 65536, 65536, 655360, 65536));
		// extreme fields and densities; on a tiny density the velocity clamps
		interface_q.push_back(pack_iface(1, 64'sh7fffffff, 64'sh7fffffff,
			1, -64'sh80000000, 64'sh7fffffff));
		interface_q.push_back(pack_iface(64'sh7fffffff, 64'sh7fffffff, 64'sh7fffffff,
			64'sh7fffffff, -64'sh80000000, 64'sh7fffffff));
		interface_q.push_back(pack_iface(1, 0, 64'sh7fffffff, 64'sh7fffffff, 0, 0));
		interface_q.push_back(pack_iface(64'sh7fffffff, 0, 0, 1, 0, 64'sh7fffffff));
		interface_q.push_back(pack_iface(65536, -65536, 163840, 65536, 65536, 163840));
		interface_q.push_back({192{1'b1}});
		interface_q.push_back({6{32'h5555_5555}});
		interface_q.push_back({6{32'h2aaa_aaaa}});
		wait_idle();

		// random phases, each under its own register setting
		for (int ph = 0; ph < 5; ph++) begin
			if (ph > 0) begin
				repeat (TOTAL_LAT + 10) @(posedge clk);
				write_reg(CFG_GAMMA, gam[ph]);
				write_reg(CFG_STEP, dts[ph]);
			end
			for (int n = 0; n < 310; n++) begin
				rand_side(rl, ml, el);
				rand_side(rr, mr, er);
				interface_q.push_back(pack_iface(rl, ml, el, rr, mr, er));
			end
			wait_idle();
		end

		repeat (TOTAL_LAT + 20) @(posedge clk);
		if (flux_expect_q.size() > 0) begin
			$display("%0t: %0d flux beats never arrived", $realtime, flux_expect_q.size());
			fail_cnt++;
		end
		$display("covered %0d interface beats over 5 register settings, %0d flux beats back",
			in_beats, out_beats);
		$display("status mix: ok %0d, density %0d, pressure %0d, clamped %0d",
			status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
		if (fail_cnt == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	initial begin
		#5ms;
		$display("Test completed with failures");
		$finish;
	end

endmodule

// ----- sim.f -----
design/erf_pkg.sv
design/erf_div.sv
design/erf_sqrt.sv
design/erf_side.sv
design/erf_flux.sv
design/euler_rusanov_flux_1d_core.sv
verif/tb_euler_rusanov_flux_1d_core.sv
